@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL modules.
// Each macro expects the enclosing module to have a clock named clock and a
// synchronous, active high reset named reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SWHS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define SWHS_ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

@@ rtl/swhs_pkg.sv @@
`timescale 1ns / 1ps

package swhs_pkg;

   localparam int unsigned TimeWidth     = 32;
   localparam int unsigned CfgWidth      = 16;
   localparam int unsigned ResultWidth   = 15;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned BitCountWidth = 5;

   // Main phase codes, also reported on the result channel.
   localparam logic [1:0] PH_START = 2'd0;
   localparam logic [1:0] PH_RECV  = 2'd1;
   localparam logic [1:0] PH_DONE  = 2'd2;
   localparam logic [1:0] PH_IDLE  = 2'd3;

   // Receiver phase codes.
   localparam logic [2:0] RX_PREAMBLE = 3'd0;
   localparam logic [2:0] RX_HUM      = 3'd1;
   localparam logic [2:0] RX_TEMP     = 3'd2;
   localparam logic [2:0] RX_SUM      = 3'd3;
   localparam logic [2:0] RX_END      = 3'd4;
   localparam logic [2:0] RX_ERROR    = 3'd5;

   // Configuration register indexes.
   localparam logic [CsrIndexWidth-1:0] CSR_START_LOW    = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_DATA_TIMEOUT = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_IDLE_DELAY   = 2'd2;

   localparam logic [CfgWidth-1:0] START_LOW_RESET    = 16'd20;
   localparam logic [CfgWidth-1:0] DATA_TIMEOUT_RESET = 16'd10;
   localparam logic [CfgWidth-1:0] IDLE_DELAY_RESET   = 16'd2000;

   // Edge interval windows in microseconds.
   localparam logic [TimeWidth-1:0] PRE_MIN_US   = 32'd129;
   localparam logic [TimeWidth-1:0] PRE_MAX_US   = 32'd180;
   localparam logic [TimeWidth-1:0] BIT0_MIN_US  = 32'd68;
   localparam logic [TimeWidth-1:0] BIT1_MIN_US  = 32'd101;
   localparam logic [TimeWidth-1:0] BIT1_LIMIT_US = 32'd160;

   localparam logic [BitCountWidth-1:0] WORD_BITS = 5'd16;
   localparam logic [BitCountWidth-1:0] SUM_BITS  = 5'd8;

   localparam logic [ResultWidth-1:0] DECIMAL_SCALE = 15'd100;

   typedef struct packed {
      logic restart;    // start pulse begins: rearm the receiver
      logic receiving;  // main phase is receiving
   } rx_ctl_type;

   typedef struct packed {
      logic failed;     // receiver saw a bad interval or a bad checksum
      logic finished;   // receiver holds a good frame
   } rx_status_type;

   // Integer byte times one hundred plus the decimal byte.
   function automatic logic [ResultWidth-1:0] pair_value(input logic [15:0] pair);
      logic [ResultWidth-1:0] hi;
      logic [ResultWidth-1:0] lo;
      hi = {7'd0, pair[15:8]};
      lo = {7'd0, pair[7:0]};
      return hi * DECIMAL_SCALE + lo;
   endfunction

endpackage

@@ rtl/swhs_rx.sv @@
`timescale 1ns / 1ps

`include "assert_macros.svh"

module swhs_rx (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     edge_en,
   input  logic [swhs_pkg::TimeWidth-1:0]           now_us,
   input  swhs_pkg::rx_ctl_type                     rx_ctl,
   output swhs_pkg::rx_status_type                  rx_status,
   output logic [swhs_pkg::ResultWidth-1:0]         hum_result_in,
   output logic [swhs_pkg::ResultWidth-1:0]         temp_result_in
);

   logic [swhs_pkg::TimeWidth-1:0]     last_edge_ff, last_edge_in;
   logic [2:0]                         recv_phase_ff, recv_phase_in;
   logic [swhs_pkg::BitCountWidth-1:0] bit_count_ff, bit_count_in;
   logic [15:0]                        hum_shift_ff, hum_shift_in;
   logic [15:0]                        temp_shift_ff, temp_shift_in;
   logic [7:0]                         sum_shift_ff, sum_shift_in;
   logic [swhs_pkg::ResultWidth-1:0]   hum_result_ff, temp_result_ff;

   logic [swhs_pkg::TimeWidth-1:0]     dt;
   logic                               bit_ok;
   logic                               bit_val;
   logic                               preamble_ok;
   logic [swhs_pkg::BitCountWidth-1:0] count_inc;
   logic [7:0]                         sum_next;
   logic [7:0]                         byte_sum;

   assign dt          = now_us - last_edge_ff;
   assign preamble_ok = (dt >= swhs_pkg::PRE_MIN_US) && (dt <= swhs_pkg::PRE_MAX_US);
   assign bit_ok      = (dt >= swhs_pkg::BIT0_MIN_US) && (dt < swhs_pkg::BIT1_LIMIT_US);
   assign bit_val     = (dt >= swhs_pkg::BIT1_MIN_US);
   assign count_inc   = bit_count_ff + 5'd1;
   assign sum_next    = {sum_shift_ff[6:0], bit_val};
   assign byte_sum    = hum_shift_ff[15:8] + hum_shift_ff[7:0]
                      + temp_shift_ff[15:8] + temp_shift_ff[7:0];

   assign rx_status.failed   = (recv_phase_ff == swhs_pkg::RX_ERROR);
   assign rx_status.finished = (recv_phase_ff == swhs_pkg::RX_END);

   always_comb begin
      last_edge_in   = last_edge_ff;
      recv_phase_in  = recv_phase_ff;
      bit_count_in   = bit_count_ff;
      hum_shift_in   = hum_shift_ff;
      temp_shift_in  = temp_shift_ff;
      sum_shift_in   = sum_shift_ff;
      hum_result_in  = hum_result_ff;
      temp_result_in = temp_result_ff;

      if (rx_ctl.restart) begin
         recv_phase_in = swhs_pkg::RX_PREAMBLE;
         bit_count_in  = '0;
      end else if (edge_en) begin
         last_edge_in = now_us;
         if (rx_ctl.receiving) begin
            case (recv_phase_ff)
               swhs_pkg::RX_PREAMBLE: begin
                  if (preamble_ok) begin
                     bit_count_in  = '0;
                     recv_phase_in = swhs_pkg::RX_HUM;
                  end
               end
               swhs_pkg::RX_HUM: begin
                  if (!bit_ok) begin
                     recv_phase_in = swhs_pkg::RX_ERROR;
                  end else begin
                     hum_shift_in = {hum_shift_ff[14:0], bit_val};
                     bit_count_in = count_inc;
                     if (count_inc >= swhs_pkg::WORD_BITS) begin
                        bit_count_in  = '0;
                        recv_phase_in = swhs_pkg::RX_TEMP;
                     end
                  end
               end
               swhs_pkg::RX_TEMP: begin
                  if (!bit_ok) begin
                     recv_phase_in = swhs_pkg::RX_ERROR;
                  end else begin
                     temp_shift_in = {temp_shift_ff[14:0], bit_val};
                     bit_count_in  = count_inc;
                     if (count_inc >= swhs_pkg::WORD_BITS) begin
                        bit_count_in  = '0;
                        recv_phase_in = swhs_pkg::RX_SUM;
                     end
                  end
               end
               swhs_pkg::RX_SUM: begin
                  if (!bit_ok) begin
                     recv_phase_in = swhs_pkg::RX_ERROR;
                  end else begin
                     sum_shift_in = sum_next;
                     bit_count_in = count_inc;
                     if (count_inc >= swhs_pkg::SUM_BITS) begin
                        // The checksum byte is complete: keep the frame only if it adds up.
                        if (byte_sum == sum_next) begin
                           hum_result_in  = swhs_pkg::pair_value(hum_shift_ff);
                           temp_result_in = swhs_pkg::pair_value(temp_shift_ff);
                           bit_count_in   = '0;
                           recv_phase_in  = swhs_pkg::RX_END;
                        end else begin
                           recv_phase_in = swhs_pkg::RX_ERROR;
                        end
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_edge_ff   <= '0;
         recv_phase_ff  <= swhs_pkg::RX_PREAMBLE;
         bit_count_ff   <= '0;
         hum_shift_ff   <= '0;
         temp_shift_ff  <= '0;
         sum_shift_ff   <= '0;
         hum_result_ff  <= '0;
         temp_result_ff <= '0;
      end else begin
         last_edge_ff   <= last_edge_in;
         recv_phase_ff  <= recv_phase_in;
         bit_count_ff   <= bit_count_in;
         hum_shift_ff   <= hum_shift_in;
         temp_shift_ff  <= temp_shift_in;
         sum_shift_ff   <= sum_shift_in;
         hum_result_ff  <= hum_result_in;
         temp_result_ff <= temp_result_in;
      end
   end

   `SWHS_ASSERT(a_bit_count_range, bit_count_ff < swhs_pkg::WORD_BITS, "rx bit count left its range")
   `SWHS_ASSERT(a_restart_clears, rx_ctl.restart |=> (recv_phase_ff == swhs_pkg::RX_PREAMBLE && bit_count_ff == '0), "rx restart did not rearm the receiver")

endmodule

@@ rtl/swhs_ctl.sv @@
`timescale 1ns / 1ps

`include "assert_macros.svh"

module swhs_ctl (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   tick_en,
   input  logic [swhs_pkg::TimeWidth-1:0]         now_ms,
   input  logic                                   csr_wr_en,
   input  logic [swhs_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [swhs_pkg::CfgWidth-1:0]          csr_wr_data,
   input  swhs_pkg::rx_status_type                rx_status,
   output swhs_pkg::rx_ctl_type                   rx_ctl,
   output logic [1:0]                             phase_in,
   output logic                                   line_low_in,
   output logic                                   ready
);

   logic [swhs_pkg::CfgWidth-1:0]  start_low_ff, data_timeout_ff, idle_delay_ff;
   logic [1:0]                     phase_ff;
   logic                           line_low_ff;
   logic                           start_issued_ff, start_issued_in;
   logic [swhs_pkg::TimeWidth-1:0] start_time_ff, start_time_in;
   logic                           recv_armed_ff, recv_armed_in;
   logic [swhs_pkg::TimeWidth-1:0] recv_start_ff, recv_start_in;
   logic                           idle_armed_ff, idle_armed_in;
   logic [swhs_pkg::TimeWidth-1:0] idle_start_ff, idle_start_in;

   logic start_expired, recv_expired, idle_expired;
   logic restart;

   // Elapsed times are wrapping differences; a timer fires once strictly past its limit.
   assign start_expired = (now_ms - start_time_ff) > {16'd0, start_low_ff};
   assign recv_expired  = (now_ms - recv_start_ff) > {16'd0, data_timeout_ff};
   assign idle_expired  = (now_ms - idle_start_ff) > {16'd0, idle_delay_ff};

   assign rx_ctl.restart   = restart;
   assign rx_ctl.receiving = (phase_ff == swhs_pkg::PH_RECV);

   always_comb begin
      phase_in        = phase_ff;
      line_low_in     = line_low_ff;
      start_issued_in = start_issued_ff;
      start_time_in   = start_time_ff;
      recv_armed_in   = recv_armed_ff;
      recv_start_in   = recv_start_ff;
      idle_armed_in   = idle_armed_ff;
      idle_start_in   = idle_start_ff;
      ready           = 1'b0;
      restart         = 1'b0;

      if (tick_en) begin
         case (phase_ff)
            swhs_pkg::PH_START: begin
               if (!start_issued_ff) begin
                  start_issued_in = 1'b1;
                  line_low_in     = 1'b1;
                  start_time_in   = now_ms;
                  recv_armed_in   = 1'b0;
                  restart         = 1'b1;
               end else if (start_expired) begin
                  line_low_in     = 1'b0;
                  start_issued_in = 1'b0;
                  phase_in        = swhs_pkg::PH_RECV;
               end
            end
            swhs_pkg::PH_RECV: begin
               if (rx_status.failed) begin
                  phase_in = swhs_pkg::PH_START;
               end else if (rx_status.finished) begin
                  phase_in = swhs_pkg::PH_DONE;
               end else if (!recv_armed_ff) begin
                  recv_armed_in = 1'b1;
                  recv_start_in = now_ms;
               end else if (recv_expired) begin
                  recv_armed_in = 1'b0;
                  phase_in      = swhs_pkg::PH_START;
               end
            end
            swhs_pkg::PH_DONE: begin
               ready    = 1'b1;
               phase_in = swhs_pkg::PH_IDLE;
            end
            default: begin
               if (!idle_armed_ff) begin
                  idle_armed_in = 1'b1;
                  idle_start_in = now_ms;
               end else if (idle_expired) begin
                  idle_armed_in = 1'b0;
                  phase_in      = swhs_pkg::PH_START;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_low_ff    <= swhs_pkg::START_LOW_RESET;
         data_timeout_ff <= swhs_pkg::DATA_TIMEOUT_RESET;
         idle_delay_ff   <= swhs_pkg::IDLE_DELAY_RESET;
         phase_ff        <= swhs_pkg::PH_START;
         line_low_ff     <= 1'b0;
         start_issued_ff <= 1'b0;
         start_time_ff   <= '0;
         recv_armed_ff   <= 1'b0;
         recv_start_ff   <= '0;
         idle_armed_ff   <= 1'b0;
         idle_start_ff   <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               swhs_pkg::CSR_START_LOW:    start_low_ff    <= csr_wr_data;
               swhs_pkg::CSR_DATA_TIMEOUT: data_timeout_ff <= csr_wr_data;
               swhs_pkg::CSR_IDLE_DELAY:   idle_delay_ff   <= csr_wr_data;
               default: begin
               end
            endcase
         end
         phase_ff        <= phase_in;
         line_low_ff     <= line_low_in;
         start_issued_ff <= start_issued_in;
         start_time_ff   <= start_time_in;
         recv_armed_ff   <= recv_armed_in;
         recv_start_ff   <= recv_start_in;
         idle_armed_ff   <= idle_armed_in;
         idle_start_ff   <= idle_start_in;
      end
   end

   `SWHS_ASSERT(a_line_low_in_start, line_low_ff |-> (phase_ff == swhs_pkg::PH_START && start_issued_ff), "line held low outside the start pulse")

endmodule

@@ rtl/single_wire_humidity_sensor_reader_top.sv @@
// Single-wire humidity and temperature sensor reader.
// Input channel (req_*): each transfer is either a poll tick (req_action 0,
// req_now_ms holds the millisecond time) or a falling edge seen on the data
// line (req_action 1, req_now_us holds the microsecond time). Poll ticks run
// the cycle: pull the line low for the start pulse, release it and receive,
// fall back to start on error or timeout, flag the reading ready, then idle.
// Result channel (rsp_*): exactly one transfer per input transfer, carrying
// the line drive, the ready flag, the last good humidity and temperature
// (integer*100 + decimal) and the main phase after that item.
// An accepted item is held in the input register until it can advance; it
// is then processed and its result loaded into the output register, which
// sets rsp_valid. Throughput is one item per cycle unless the result
// channel stalls, set by the single pass from the input register through
// the control and receive logic into the output register.
// When the receiver stalls, the result waits in the output register while
// one more item may be taken into the input register; req_stall rises only
// when both hold an item. Configuration (csr_*) writes bypass both stages.
// Synchronous reset restores the register defaults, clears both stages and
// returns the reader to the start phase with the line released.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module single_wire_humidity_sensor_reader_top (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_action,
   input  logic [swhs_pkg::TimeWidth-1:0]        req_now_ms,
   input  logic [swhs_pkg::TimeWidth-1:0]        req_now_us,
   // Result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_drive_low,
   output logic                                  rsp_data_ready,
   output logic [swhs_pkg::ResultWidth-1:0]      rsp_humidity,
   output logic [swhs_pkg::ResultWidth-1:0]      rsp_temperature,
   output logic [1:0]                            rsp_phase,
   // Configuration write port
   input  logic                                  csr_wr_en,
   input  logic [swhs_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [swhs_pkg::CfgWidth-1:0]         csr_wr_data
);

   // Input register stage.
   logic                           in_valid_ff;
   logic                           in_action_ff;
   logic [swhs_pkg::TimeWidth-1:0] in_now_ms_ff;
   logic [swhs_pkg::TimeWidth-1:0] in_now_us_ff;

   // Output register stage.
   logic                             rsp_valid_ff;
   logic                             rsp_drive_low_ff;
   logic                             rsp_data_ready_ff;
   logic [swhs_pkg::ResultWidth-1:0] rsp_humidity_ff;
   logic [swhs_pkg::ResultWidth-1:0] rsp_temperature_ff;
   logic [1:0]                       rsp_phase_ff;

   logic req_take;
   logic advance;
   logic tick_en;
   logic edge_en;

   swhs_pkg::rx_ctl_type             rx_ctl;
   swhs_pkg::rx_status_type          rx_status;
   logic [1:0]                       phase_in;
   logic                             line_low_in;
   logic                             ready;
   logic [swhs_pkg::ResultWidth-1:0] hum_result_in;
   logic [swhs_pkg::ResultWidth-1:0] temp_result_in;

   // The held item moves on whenever the output register is empty or being drained.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign tick_en   = advance && !in_action_ff;
   assign edge_en   = advance && in_action_ff;

   swhs_ctl u_ctl (
      .clock       (clock),
      .reset       (reset),
      .tick_en     (tick_en),
      .now_ms      (in_now_ms_ff),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .rx_status   (rx_status),
      .rx_ctl      (rx_ctl),
      .phase_in    (phase_in),
      .line_low_in (line_low_in),
      .ready       (ready)
   );

   swhs_rx u_rx (
      .clock          (clock),
      .reset          (reset),
      .edge_en        (edge_en),
      .now_us         (in_now_us_ff),
      .rx_ctl         (rx_ctl),
      .rx_status      (rx_status),
      .hum_result_in  (hum_result_in),
      .temp_result_in (temp_result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= req_action;
         in_now_ms_ff <= req_now_ms;
         in_now_us_ff <= req_now_us;
      end
      if (advance) begin
         rsp_drive_low_ff   <= line_low_in;
         rsp_data_ready_ff  <= ready;
         rsp_humidity_ff    <= hum_result_in;
         rsp_temperature_ff <= temp_result_in;
         rsp_phase_ff       <= phase_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_low   = rsp_drive_low_ff;
   assign rsp_data_ready  = rsp_data_ready_ff;
   assign rsp_humidity    = rsp_humidity_ff;
   assign rsp_temperature = rsp_temperature_ff;
   assign rsp_phase       = rsp_phase_ff;

   `SWHS_ASSERT(a_ready_enters_idle, (rsp_valid_ff && rsp_data_ready_ff) |-> (rsp_phase_ff == swhs_pkg::PH_IDLE), "ready reported outside the idle phase")
   `SWHS_ASSERT(a_drive_only_start, (rsp_valid_ff && rsp_drive_low_ff) |-> (rsp_phase_ff == swhs_pkg::PH_START), "line reported low outside the start phase")
   `SWHS_ASSERT_NEVER(a_stall_without_item, req_stall && !in_valid_ff, "input stalled with an empty input register")

endmodule
